// ===== src/rhc_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
`timescale 1ns / 1ps
package rhc_pkg;
  localparam int CHANNEL_BITS_DEF = 16;
  localparam int CFG_BITS = 16;
  localparam logic [CFG_BITS-1:0] GRAY_THRESHOLD_RST = 16'd66;

  // Control that travels down the row beside the data.
  typedef struct packed {
    logic valid;
    logic gray;
  } ctl_t;
endpackage

// ===== src/rhc_front.sv =====
// Front stage: max, min, delta, hue numerator and divider seeds.
`timescale 1ns / 1ps
module rhc_front #(
  parameter int W = rhc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [W-1:0]                  red,
  input  logic [W-1:0]                  green,
  input  logic [W-1:0]                  blue,
  input  logic [rhc_pkg::CFG_BITS-1:0]  thr,
  output rhc_pkg::ctl_t                 ctl,
  output logic [W-1:0]                  mx,
  output logic [W-1:0]                  sat_rem,
  output logic [W-1:0]                  sat_low,
  output logic [W+2:0]                  hue_rem,
  output logic [W+2:0]                  hue_div
);
  localparam int CW = (W > rhc_pkg::CFG_BITS) ? W : rhc_pkg::CFG_BITS;

  logic [W-1:0]     mx_c, mn_c, delta;
  logic [2*W-1:0]   dvd;
  logic signed [W+3:0] num, num_w;
  logic             gray_c;

  always_comb begin
    mx_c = red;
    if (green > mx_c) mx_c = green;
    if (blue > mx_c) mx_c = blue;
    mn_c = red;
    if (green < mn_c) mn_c = green;
    if (blue < mn_c) mn_c = blue;
    delta = mx_c - mn_c;
    gray_c = (CW'(delta) < CW'(thr)) || (delta == '0);
    // Saturation dividend: delta * full scale.
    dvd = {delta, {W{1'b0}}} - (2*W)'(delta);
    if (red >= mx_c) begin
      num = $signed({4'b0, green}) - $signed({4'b0, blue});
    end else if (green >= mx_c) begin
      num = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, blue}) - $signed({4'b0, red});
    end else begin
      num = $signed({2'b0, delta, 2'b0}) + $signed({4'b0, red}) - $signed({4'b0, green});
    end
    // Wrap a negative hue by one turn.
    num_w = num;
    if (num < 0) begin
      num_w = num + $signed({2'b0, delta, 2'b0}) + $signed({3'b0, delta, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= take;
      ctl.gray  <= gray_c;
    end
  end

  always_ff @(posedge clk) begin
    mx      <= mx_c;
    sat_rem <= dvd[2*W-1:W];
    sat_low <= dvd[W-1:0];
    hue_rem <= num_w[W+2:0];
    hue_div <= ({3'b0, delta} << 2) + ({3'b0, delta} << 1);
  end
endmodule

// ===== src/rhc_cell.sv =====
// One divider cell: retires one quotient bit of saturation and of hue.
`timescale 1ns / 1ps
module rhc_cell #(
  parameter int W = rhc_pkg::CHANNEL_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rhc_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  mx_i,
  input  logic [W-1:0]  sat_rem_i,
  input  logic [W-1:0]  sat_low_i,
  input  logic [W-1:0]  sat_q_i,
  input  logic [W+2:0]  hue_rem_i,
  input  logic [W+2:0]  hue_div_i,
  input  logic [W-1:0]  hue_q_i,
  output rhc_pkg::ctl_t ctl_o,
  output logic [W-1:0]  mx_o,
  output logic [W-1:0]  sat_rem_o,
  output logic [W-1:0]  sat_low_o,
  output logic [W-1:0]  sat_q_o,
  output logic [W+2:0]  hue_rem_o,
  output logic [W+2:0]  hue_div_o,
  output logic [W-1:0]  hue_q_o
);
  logic [W:0]   s_t, s_d;
  logic [W+3:0] h_t, h_d;
  logic         s_bit, h_bit;

  always_comb begin
    s_t   = {sat_rem_i, sat_low_i[W-1]};
    s_d   = s_t - {1'b0, mx_i};
    s_bit = (s_t >= {1'b0, mx_i});
    h_t   = {hue_rem_i, 1'b0};
    h_d   = h_t - {1'b0, hue_div_i};
    h_bit = (h_t >= {1'b0, hue_div_i});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    mx_o      <= mx_i;
    sat_rem_o <= s_bit ? s_d[W-1:0] : s_t[W-1:0];
    sat_low_o <= sat_low_i << 1;
    sat_q_o   <= {sat_q_i[W-2:0], s_bit};
    hue_rem_o <= h_bit ? h_d[W+2:0] : h_t[W+2:0];
    hue_div_o <= hue_div_i;
    hue_q_o   <= {hue_q_i[W-2:0], h_bit};
  end
endmodule

// ===== src/rgb_to_hsv_convert_core.sv =====
// Top level of the RGB to HSV converter: front stage and a row of divider cells.
`timescale 1ns / 1ps
// Converts one RGB pixel per clock into hue, saturation and brightness. A
// pixel is taken at every edge with start high; busy never rises, so pixels
// may follow back to back. Each result appears on done for one cycle once
// its start beat has passed every register of the pipeline in order: one
// front stage finds max, min and the hue numerator, then a row of
// CHANNEL_BITS cells each retires one quotient bit of both divisions. The
// receiver cannot stall, so results must be taken as they appear. Write
// gray_threshold only while no pixel is in flight; cfg_ready is always high.
module rgb_to_hsv_convert_core #(
  parameter int CHANNEL_BITS = rhc_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [CHANNEL_BITS-1:0]       red,
  input  logic [CHANNEL_BITS-1:0]       green,
  input  logic [CHANNEL_BITS-1:0]       blue,
  output logic                          done,
  output logic [CHANNEL_BITS-1:0]       hue,
  output logic [CHANNEL_BITS-1:0]       saturation,
  output logic [CHANNEL_BITS-1:0]       brightness,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rhc_pkg::CFG_BITS-1:0]  cfg_data
);
  localparam int W = CHANNEL_BITS;

  logic [rhc_pkg::CFG_BITS-1:0] gray_threshold;

  // Taps between cells; index 0 is the front stage output.
  rhc_pkg::ctl_t ctl     [W+1];
  logic [W-1:0]  mx      [W+1];
  logic [W-1:0]  sat_rem [W+1];
  logic [W-1:0]  sat_low [W+1];
  logic [W-1:0]  sat_q   [W+1];
  logic [W+2:0]  hue_rem [W+1];
  logic [W+2:0]  hue_div [W+1];
  logic [W-1:0]  hue_q   [W+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Hold the threshold; load on a config beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= rhc_pkg::GRAY_THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      gray_threshold <= cfg_data;
    end
  end

  rhc_front #(.W(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (start && !busy),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .thr     (gray_threshold),
    .ctl     (ctl[0]),
    .mx      (mx[0]),
    .sat_rem (sat_rem[0]),
    .sat_low (sat_low[0]),
    .hue_rem (hue_rem[0]),
    .hue_div (hue_div[0])
  );

  assign sat_q[0] = '0;
  assign hue_q[0] = '0;

  // Advance every pixel one cell per cycle, one quotient bit per cell.
  for (genvar i = 0; i < W; i++) begin : g_cell
    rhc_cell #(.W(W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_i     (ctl[i]),
      .mx_i      (mx[i]),
      .sat_rem_i (sat_rem[i]),
      .sat_low_i (sat_low[i]),
      .sat_q_i   (sat_q[i]),
      .hue_rem_i (hue_rem[i]),
      .hue_div_i (hue_div[i]),
      .hue_q_i   (hue_q[i]),
      .ctl_o     (ctl[i+1]),
      .mx_o      (mx[i+1]),
      .sat_rem_o (sat_rem[i+1]),
      .sat_low_o (sat_low[i+1]),
      .sat_q_o   (sat_q[i+1]),
      .hue_rem_o (hue_rem[i+1]),
      .hue_div_o (hue_div[i+1]),
      .hue_q_o   (hue_q[i+1])
    );
  end

  // Drop hue and saturation to zero for gray or black pixels.
  assign done       = ctl[W].valid;
  assign brightness = mx[W];
  assign hue        = ctl[W].gray ? '0 : hue_q[W];
  assign saturation = ctl[W].gray ? '0 : sat_q[W];
endmodule

// ===== src/rhc_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps
module rhc_checker #(
  parameter int W = rhc_pkg::CHANNEL_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input logic         done,
  input logic [W-1:0] hue,
  input logic [W-1:0] saturation,
  input logic [W-1:0] brightness
);
  localparam int LAT = W + 1;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching start beat");

  a_black: assert property (@(posedge clk) disable iff (rst)
    (done && brightness == '0) |-> (hue == '0 && saturation == '0))
    else $error("black pixel with nonzero hue or saturation");

  a_sat_le: assert property (@(posedge clk) disable iff (rst)
    (done && saturation != '0) |-> brightness != '0)
    else $error("saturation without brightness");
endmodule

bind rgb_to_hsv_convert_core rhc_checker #(.W(CHANNEL_BITS)) u_rhc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .hue        (hue),
  .saturation (saturation),
  .brightness (brightness)
);
